// ===== design/sasalu_pkg.sv =====
// ----------------------------------------------------------------------------
// sasalu_pkg
// Shared types and constants for the sized add/subtract/shift ALU pipeline.
// ----------------------------------------------------------------------------
package sasalu_pkg;

    localparam int DATA_W = 64;
    localparam int SIZE_W = 7;
    localparam int CNT_W  = 8;
    localparam int IDX_W  = 6;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_ASL = 3'd2,
        CMD_ASR = 3'd3,
        CMD_LSL = 3'd4,
        CMD_LSR = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_WORD = 2'd1,
        SZ_DWORD = 2'd2,
        SZ_LONG = 2'd3
    } t_size;

    typedef struct packed {
        t_cmd              cmd;
        logic              touched;
        logic [DATA_W-1:0] dst;
        logic [DATA_W-1:0] d;
        logic [DATA_W-1:0] s;
        logic [DATA_W-1:0] de;
        logic [DATA_W-1:0] m;
        logic [DATA_W-1:0] topm;
        logic [DATA_W-1:0] hm;
        logic [SIZE_W-1:0] w;
        logic [CNT_W-1:0]  cnt;
        logic              c;
        logic              x;
        logic              z;
        logic              n;
        logic              v;
    } t_dec;

    typedef struct packed {
        logic              touched;
        logic              arith;
        logic [DATA_W-1:0] dst;
        logic [DATA_W-1:0] r;
        logic [DATA_W-1:0] m;
        logic [DATA_W-1:0] topm;
        logic              c;
        logic              x;
        logic              z;
        logic              n;
        logic              v;
    } t_exe;

endpackage

// ===== design/sized_add_sub_shift_alu_unit.sv =====
// ----------------------------------------------------------------------------
// sized_add_sub_shift_alu_unit
// Sized add, subtract and shift ALU with condition flags, three-stage pipeline.
// ----------------------------------------------------------------------------
// An item is taken every cycle; busy is always low. Each item's result
// passes through the three register stages in order (decode, execute with
// adder and barrel shifters, flag and merge) and appears on the outputs,
// marked by o_valid for one cycle, in the order the items were taken.
// The receiver must take every result in the cycle it appears.
// ----------------------------------------------------------------------------
module sized_add_sub_shift_alu_unit
    import sasalu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_cmd,
    input  logic [1:0]        i_op_size,
    input  logic              i_dst_is_register,
    input  logic [DATA_W-1:0] i_dst_value,
    input  logic [DATA_W-1:0] i_src_value,
    input  logic              i_carry_in,
    input  logic              i_extend_in,
    input  logic              i_zero_in,
    input  logic              i_negative_in,
    input  logic              i_overflow_in,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_result,
    output logic              o_carry_out,
    output logic              o_extend_out,
    output logic              o_zero_out,
    output logic              o_negative_out,
    output logic              o_overflow_out
);

    logic dec_valid;
    t_dec dec;
    logic exe_valid;
    t_exe exe;

    assign busy = 1'b0;

    sasalu_decode u_decode (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (start && !busy),
        .i_cmd             (i_cmd),
        .i_op_size         (i_op_size),
        .i_dst_is_register (i_dst_is_register),
        .i_dst_value       (i_dst_value),
        .i_src_value       (i_src_value),
        .i_carry_in        (i_carry_in),
        .i_extend_in       (i_extend_in),
        .i_zero_in         (i_zero_in),
        .i_negative_in     (i_negative_in),
        .i_overflow_in     (i_overflow_in),
        .o_valid           (dec_valid),
        .o_dec             (dec)
    );

    sasalu_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .i_dec   (dec),
        .o_valid (exe_valid),
        .o_exe   (exe)
    );

    sasalu_wb u_wb (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (exe_valid),
        .i_exe          (exe),
        .o_valid        (o_valid),
        .o_result       (o_result),
        .o_carry_out    (o_carry_out),
        .o_extend_out   (o_extend_out),
        .o_zero_out     (o_zero_out),
        .o_negative_out (o_negative_out),
        .o_overflow_out (o_overflow_out)
    );

endmodule

// ===== design/sasalu_decode.sv =====
// ----------------------------------------------------------------------------
// sasalu_decode
// First stage: size masks, sized operands, sign extension and shift count.
// ----------------------------------------------------------------------------
module sasalu_decode
    import sasalu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [2:0]        i_cmd,
    input  logic [1:0]        i_op_size,
    input  logic              i_dst_is_register,
    input  logic [DATA_W-1:0] i_dst_value,
    input  logic [DATA_W-1:0] i_src_value,
    input  logic              i_carry_in,
    input  logic              i_extend_in,
    input  logic              i_zero_in,
    input  logic              i_negative_in,
    input  logic              i_overflow_in,
    output logic              o_valid,
    output t_dec              o_dec
);

    logic              r_valid;
    t_dec              r_dec;
    t_dec              n_dec;
    logic [DATA_W-1:0] m;
    logic [SIZE_W-1:0] w;
    logic [CNT_W:0]    hm_shift;
    logic              sign;

    always_comb begin
        unique case (t_size'(i_op_size))
            SZ_BYTE: begin
                m = {{(DATA_W-8){1'b0}}, 8'hFF};
                w = SIZE_W'(8);
            end
            SZ_WORD: begin
                m = {{(DATA_W-16){1'b0}}, 16'hFFFF};
                w = SIZE_W'(16);
            end
            SZ_DWORD: begin
                m = {{(DATA_W-32){1'b0}}, 32'hFFFF_FFFF};
                w = SIZE_W'(32);
            end
            SZ_LONG: begin
                m = {DATA_W{1'b1}};
                w = SIZE_W'(DATA_W);
            end
        endcase
    end

    always_comb begin
        hm_shift     = {1'b0, i_src_value[CNT_W-1:0]} + (CNT_W+1)'(1);
        n_dec.cmd    = t_cmd'(i_cmd);
        n_dec.touched = i_dst_is_register && (i_cmd <= CMD_LSR);
        n_dec.dst    = i_dst_value;
        n_dec.d      = i_dst_value & m;
        n_dec.s      = i_src_value & m;
        n_dec.m      = m;
        n_dec.topm   = m ^ (m >> 1);
        sign         = |(i_dst_value & n_dec.topm);
        n_dec.de     = n_dec.d | (sign ? ~m : '0);
        n_dec.hm     = m & ~(m >> hm_shift);
        n_dec.w      = w;
        n_dec.cnt    = i_src_value[CNT_W-1:0];
        n_dec.c      = i_carry_in;
        n_dec.x      = i_extend_in;
        n_dec.z      = i_zero_in;
        n_dec.n      = i_negative_in;
        n_dec.v      = i_overflow_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec <= n_dec;
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

// ===== design/sasalu_exec.sv =====
// ----------------------------------------------------------------------------
// sasalu_exec
// Second stage: adder, subtractor and barrel shifters with C, X and V.
// ----------------------------------------------------------------------------
module sasalu_exec
    import sasalu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_dec i_dec,
    output logic o_valid,
    output t_exe o_exe
);

    logic              r_valid;
    t_exe              r_exe;
    t_exe              n_exe;
    logic [DATA_W:0]   sum;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] add_r;
    logic [DATA_W-1:0] sub_r;
    logic [DATA_W-1:0] shl_r;
    logic [DATA_W-1:0] lsr_r;
    logic [DATA_W-1:0] asr_r;
    logic              cnt_zero;
    logic              cnt_lt_w;
    logic              cnt_le_w;
    logic [IDX_W-1:0]  asr_amt;
    logic [CNT_W-1:0]  cnt_m1;
    logic [IDX_W-1:0]  asr_idx;
    logic [SIZE_W-1:0] asl_diff;
    logic              asl_c;
    logic              asl_v;
    logic              asr_c;

    always_comb begin
        sum      = {1'b0, i_dec.d} + {1'b0, i_dec.s};
        diff     = {1'b0, i_dec.d} - {1'b0, i_dec.s};
        add_r    = sum[DATA_W-1:0] & i_dec.m;
        sub_r    = diff[DATA_W-1:0] & i_dec.m;
        cnt_zero = (i_dec.cnt == '0);
        cnt_lt_w = (i_dec.cnt < {1'b0, i_dec.w});
        cnt_le_w = (i_dec.cnt <= {1'b0, i_dec.w});
        shl_r    = cnt_lt_w ? ((i_dec.d << i_dec.cnt[IDX_W-1:0]) & i_dec.m) : '0;
        lsr_r    = cnt_lt_w ? (i_dec.d >> i_dec.cnt[IDX_W-1:0]) : '0;
        asr_amt  = (i_dec.cnt > CNT_W'(DATA_W-1)) ? IDX_W'(DATA_W-1)
                                                  : i_dec.cnt[IDX_W-1:0];
        asr_r    = DATA_W'($signed(i_dec.de) >>> asr_amt) & i_dec.m;
        cnt_m1   = i_dec.cnt - CNT_W'(1);
        asr_idx  = (cnt_m1 > CNT_W'(DATA_W-1)) ? IDX_W'(DATA_W-1) : cnt_m1[IDX_W-1:0];
        asr_c    = i_dec.de[asr_idx];
        asl_diff = i_dec.w - i_dec.cnt[SIZE_W-1:0];
        asl_c    = cnt_le_w ? i_dec.d[asl_diff[IDX_W-1:0]] : 1'b0;
        if (cnt_lt_w) begin
            asl_v = ((i_dec.d & i_dec.hm) != '0) && ((i_dec.d & i_dec.hm) != i_dec.hm);
        end else begin
            asl_v = (i_dec.d != '0);
        end
    end

    always_comb begin
        n_exe.touched = i_dec.touched;
        n_exe.arith   = 1'b0;
        n_exe.dst     = i_dec.dst;
        n_exe.r       = i_dec.d;
        n_exe.m       = i_dec.m;
        n_exe.topm    = i_dec.topm;
        n_exe.c       = i_dec.c;
        n_exe.x       = i_dec.x;
        n_exe.z       = i_dec.z;
        n_exe.n       = i_dec.n;
        n_exe.v       = i_dec.v;
        if (i_dec.touched) begin
            unique case (i_dec.cmd)
                CMD_ADD: begin
                    n_exe.r     = add_r;
                    n_exe.c     = sum[i_dec.w];
                    n_exe.x     = sum[i_dec.w];
                    n_exe.v     = |((i_dec.s ^ add_r) & (i_dec.d ^ add_r) & i_dec.topm);
                    n_exe.arith = 1'b1;
                end
                CMD_SUB: begin
                    n_exe.r     = sub_r;
                    n_exe.c     = diff[DATA_W];
                    n_exe.x     = diff[DATA_W];
                    n_exe.v     = |((i_dec.s ^ i_dec.d) & (sub_r ^ i_dec.d) & i_dec.topm);
                    n_exe.arith = 1'b1;
                end
                CMD_ASL: begin
                    n_exe.arith = 1'b1;
                    if (cnt_zero) begin
                        n_exe.c = 1'b0;
                        n_exe.v = 1'b0;
                    end else begin
                        n_exe.r = shl_r;
                        n_exe.c = asl_c;
                        n_exe.x = asl_c;
                        n_exe.v = asl_v;
                    end
                end
                CMD_ASR: begin
                    n_exe.arith = 1'b1;
                    n_exe.v     = 1'b0;
                    if (cnt_zero) begin
                        n_exe.c = 1'b0;
                    end else begin
                        n_exe.r = asr_r;
                        n_exe.c = asr_c;
                        n_exe.x = asr_c;
                    end
                end
                CMD_LSL: begin
                    n_exe.r = shl_r;
                end
                CMD_LSR: begin
                    n_exe.r = lsr_r;
                end
                default: begin
                    n_exe.touched = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_exe <= n_exe;
    end

    assign o_valid = r_valid;
    assign o_exe   = r_exe;

endmodule

// ===== design/sasalu_wb.sv =====
// ----------------------------------------------------------------------------
// sasalu_wb
// Third stage: Z and N from the sized result of arithmetic commands and merge into the destination.
// ----------------------------------------------------------------------------
module sasalu_wb
    import sasalu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_exe              i_exe,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_result,
    output logic              o_carry_out,
    output logic              o_extend_out,
    output logic              o_zero_out,
    output logic              o_negative_out,
    output logic              o_overflow_out
);

    logic              r_valid;
    logic [DATA_W-1:0] r_result;
    logic              r_c;
    logic              r_x;
    logic              r_z;
    logic              r_n;
    logic              r_v;
    logic [DATA_W-1:0] n_result;
    logic              n_z;
    logic              n_n;

    always_comb begin
        n_result = i_exe.touched ? ((i_exe.dst & ~i_exe.m) | (i_exe.r & i_exe.m))
                                 : i_exe.dst;
        n_z      = i_exe.arith ? (i_exe.r == '0) : i_exe.z;
        n_n      = i_exe.arith ? |(i_exe.r & i_exe.topm) : i_exe.n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_c      <= i_exe.c;
        r_x      <= i_exe.x;
        r_z      <= n_z;
        r_n      <= n_n;
        r_v      <= i_exe.v;
    end

    assign o_valid        = r_valid;
    assign o_result       = r_result;
    assign o_carry_out    = r_c;
    assign o_extend_out   = r_x;
    assign o_zero_out     = r_z;
    assign o_negative_out = r_n;
    assign o_overflow_out = r_v;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sized add/subtract/shift ALU. Directed items
// cover the carry, borrow and overflow edges, shift counts around the operand
// width and the pass-through cases; random items follow in bursts with random
// gaps. Every result is compared with a flag-accurate prediction in order.
// ----------------------------------------------------------------------------
module testbench;
    import sasalu_pkg::*;

    localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_ITEMS = 1900;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef struct {
        logic [2:0]  cmd;
        t_size       size;
        logic        dst_reg;
        logic [63:0] dst;
        logic [63:0] src;
        logic        c, x, z, n, v;
    } t_alu_op;

    typedef struct {
        logic [63:0] result;
        logic        c, x, z, n, v;
    } t_alu_out;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [2:0]        i_cmd;
    logic [1:0]        i_op_size;
    logic              i_dst_is_register;
    logic [DATA_W-1:0] i_dst_value;
    logic [DATA_W-1:0] i_src_value;
    logic              i_carry_in;
    logic              i_extend_in;
    logic              i_zero_in;
    logic              i_negative_in;
    logic              i_overflow_in;
    logic              o_valid;
    logic [DATA_W-1:0] o_result;
    logic              o_carry_out;
    logic              o_extend_out;
    logic              o_zero_out;
    logic              o_negative_out;
    logic              o_overflow_out;

    t_alu_out    pending_alu_out[$];
    t_alu_out    due;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned burst_left = 0;
    bit          gaps_on = 1'b1;

    sized_add_sub_shift_alu_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cmd             (i_cmd),
        .i_op_size         (i_op_size),
        .i_dst_is_register (i_dst_is_register),
        .i_dst_value       (i_dst_value),
        .i_src_value       (i_src_value),
        .i_carry_in        (i_carry_in),
        .i_extend_in       (i_extend_in),
        .i_zero_in         (i_zero_in),
        .i_negative_in     (i_negative_in),
        .i_overflow_in     (i_overflow_in),
        .o_valid           (o_valid),
        .o_result          (o_result),
        .o_carry_out       (o_carry_out),
        .o_extend_out      (o_extend_out),
        .o_zero_out        (o_zero_out),
        .o_negative_out    (o_negative_out),
        .o_overflow_out    (o_overflow_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned size_width(t_size size);
        case (size)
            SZ_BYTE:  return 8;
            SZ_WORD:  return 16;
            SZ_DWORD: return 32;
            default:  return 64;
        endcase
    endfunction

    function automatic logic [63:0] size_mask(t_size size);
        int unsigned w;
        w = size_width(size);
        return (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    function automatic t_alu_out compute_alu(t_alu_op op);
        int unsigned w;
        int unsigned cnt;
        logic [63:0] m, d, s, r, top, ones;
        logic        sign;
        logic        arith;
        t_alu_out    res;
        w = size_width(op.size);
        m = size_mask(op.size);
        d = op.dst & m;
        s = op.src & m;
        cnt = {24'd0, op.src[7:0]};
        r = d;
        arith = 1'b0;
        res.result = op.dst;
        res.c = op.c;
        res.x = op.x;
        res.z = op.z;
        res.n = op.n;
        res.v = op.v;
        if (!op.dst_reg || op.cmd > CMD_LSR) begin
            return res;
        end
        case (op.cmd)
            CMD_ADD: begin
                r = (d + s) & m;
                res.c = (r < d);
                res.x = res.c;
                res.v = ((((s ^ r) & (d ^ r)) >> (w - 1)) & 64'd1) != 0;
                arith = 1'b1;
            end
            CMD_SUB: begin
                r = (d - s) & m;
                res.c = (s > d);
                res.x = res.c;
                res.v = ((((s ^ d) & (r ^ d)) >> (w - 1)) & 64'd1) != 0;
                arith = 1'b1;
            end
            CMD_ASL: begin
                if (cnt == 0) begin
                    res.c = 1'b0;
                    res.v = 1'b0;
                end else if (cnt < w) begin
                    top = d >> (w - 1 - cnt);
                    ones = m >> (w - 1 - cnt);
                    r = (d << cnt) & m;
                    res.c = ((d >> (w - cnt)) & 64'd1) != 0;
                    res.x = res.c;
                    res.v = (top != 0) && (top != ones);
                end else begin
                    r = '0;
                    res.c = (cnt == w) ? d[0] : 1'b0;
                    res.x = res.c;
                    res.v = (d != 0);
                end
                arith = 1'b1;
            end
            CMD_ASR: begin
                sign = ((d >> (w - 1)) & 64'd1) != 0;
                if (cnt == 0) begin
                    res.c = 1'b0;
                end else if (cnt < w) begin
                    r = d >> cnt;
                    if (sign) begin
                        r = r | (m & ~(m >> cnt));
                    end
                    res.c = ((d >> (cnt - 1)) & 64'd1) != 0;
                    res.x = res.c;
                end else begin
                    r = sign ? m : '0;
                    res.c = sign;
                    res.x = sign;
                end
                res.v = 1'b0;
                arith = 1'b1;
            end
            CMD_LSL: begin
                r = (cnt < w) ? ((d << cnt) & m) : '0;
            end
            default: begin
                r = (cnt < w) ? (d >> cnt) : '0;
            end
        endcase
        if (arith) begin
            res.z = (r == 0);
            res.n = ((r >> (w - 1)) & 64'd1) != 0;
        end
        res.result = (op.dst & ~m) | (r & m);
        return res;
    endfunction

    function automatic t_alu_op make_op(logic [2:0] cmd, t_size size, logic dst_reg,
                                        logic [63:0] dst, logic [63:0] src);
        t_alu_op     op;
        logic [31:0] flags;
        flags = $urandom;
        op.cmd = cmd;
        op.size = size;
        op.dst_reg = dst_reg;
        op.dst = dst;
        op.src = src;
        {op.c, op.x, op.z, op.n, op.v} = flags[4:0];
        return op;
    endfunction

    function automatic logic [63:0] with_count(int unsigned cnt);
        return ({$urandom, $urandom} & ~64'hFF) | (64'(cnt) & 64'hFF);
    endfunction

    function automatic logic [63:0] pick_operand(t_size size);
        logic [63:0] m, val;
        m = size_mask(size);
        val = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: val = val & ~m;
            1: val = val | m;
            2: val = (val & ~m) | (m >> 1);
            3: val = (val & ~m) | ((m >> 1) + 64'd1);
            4: val = (val & ~m) | 64'd1;
            default: ;
        endcase
        return val;
    endfunction

    task automatic send_op(t_alu_op op);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start             <= 1'b1;
        i_cmd             <= op.cmd;
        i_op_size         <= op.size;
        i_dst_is_register <= op.dst_reg;
        i_dst_value       <= op.dst;
        i_src_value       <= op.src;
        i_carry_in        <= op.c;
        i_extend_in       <= op.x;
        i_zero_in         <= op.z;
        i_negative_in     <= op.n;
        i_overflow_in     <= op.v;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_alu_out.push_back(compute_alu(op));
    endtask

    task automatic test_add_sub_edges();
        send_op(make_op(CMD_ADD, SZ_BYTE, 1'b1, 64'hA5A5_0000_1234_567F, 64'h01));
        send_op(make_op(CMD_ADD, SZ_BYTE, 1'b1, 64'h0000_0000_0000_00FF, 64'h01));
        send_op(make_op(CMD_SUB, SZ_BYTE, 1'b1, 64'hFFFF_FFFF_FFFF_FF00, 64'h01));
        send_op(make_op(CMD_SUB, SZ_WORD, 1'b1, 64'h0000_0000_0000_8000, 64'h01));
        send_op(make_op(CMD_ADD, SZ_DWORD, 1'b1, 64'h1234_5678_FFFF_FFFF, '1));
        send_op(make_op(CMD_ADD, SZ_LONG, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 64'h1));
        send_op(make_op(CMD_SUB, SZ_LONG, 1'b1, 64'h8000_0000_0000_0000, 64'h1));
        send_op(make_op(CMD_SUB, SZ_LONG, 1'b1, '1, '1));
    endtask

    task automatic test_shift_counts();
        send_op(make_op(CMD_ASL, SZ_BYTE, 1'b1, 64'h81, with_count(0)));
        send_op(make_op(CMD_ASL, SZ_BYTE, 1'b1, 64'hFF00_0000_0000_0003, with_count(8)));
        send_op(make_op(CMD_ASL, SZ_WORD, 1'b1, 64'hFFFF, with_count(17)));
        send_op(make_op(CMD_ASL, SZ_LONG, 1'b1, 64'h4000_0000_0000_0001, with_count(1)));
        send_op(make_op(CMD_ASL, SZ_LONG, 1'b1, 64'h1, with_count(64)));
        send_op(make_op(CMD_ASR, SZ_BYTE, 1'b1, 64'h96, with_count(3)));
        send_op(make_op(CMD_ASR, SZ_WORD, 1'b1, 64'h8001, with_count(16)));
        send_op(make_op(CMD_ASR, SZ_LONG, 1'b1, 64'h8000_0000_0000_0000, with_count(255)));
        send_op(make_op(CMD_LSL, SZ_DWORD, 1'b1, '1, with_count(31)));
        send_op(make_op(CMD_LSL, SZ_BYTE, 1'b1, '1, with_count(8)));
        send_op(make_op(CMD_LSR, SZ_LONG, 1'b1, '1, with_count(63)));
        send_op(make_op(CMD_LSR, SZ_WORD, 1'b1, '1, with_count(200)));
    endtask

    task automatic test_passthrough_cases();
        send_op(make_op(CMD_ADD, SZ_LONG, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h1));
        send_op(make_op(CMD_UNUSED_LO, SZ_BYTE, 1'b1, {$urandom, $urandom}, '1));
        send_op(make_op(CMD_UNUSED_HI, SZ_WORD, 1'b1, {$urandom, $urandom}, '1));
        send_op(make_op(CMD_ADD, SZ_BYTE, 1'b1, 64'h10, 64'hFFFF_FFFF_FFFF_FF01));
    endtask

    task automatic test_random_ops();
        t_alu_op     op;
        t_size       size;
        logic [2:0]  cmd;
        int unsigned w;
        for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
            gaps_on = ((i / 150) % 3) != 0;
            size = t_size'($urandom_range(0, 3));
            w = size_width(size);
            cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
            op = make_op(cmd, size, $urandom_range(0, 19) != 0, pick_operand(size),
                         pick_operand(size));
            if (cmd >= CMD_ASL && cmd <= CMD_LSR && $urandom_range(0, 9) < 7) begin
                op.src = with_count($urandom_range(0, w + 1));
            end
            send_op(op);
        end
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (o_valid === 1'b1) begin
            if (pending_alu_out.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_result);
                mismatches++;
            end else begin
                due = pending_alu_out.pop_front();
                if (o_result !== due.result) begin
                    $display("%0t: result expected %h, actual %h", $time, due.result, o_result);
                    mismatches++;
                end
                if (o_carry_out !== due.c) begin
                    $display("%0t: carry expected %b, actual %b", $time, due.c, o_carry_out);
                    mismatches++;
                end
                if (o_extend_out !== due.x) begin
                    $display("%0t: extend expected %b, actual %b", $time, due.x, o_extend_out);
                    mismatches++;
                end
                if (o_zero_out !== due.z) begin
                    $display("%0t: zero expected %b, actual %b", $time, due.z, o_zero_out);
                    mismatches++;
                end
                if (o_negative_out !== due.n) begin
                    $display("%0t: negative expected %b, actual %b", $time, due.n,
                             o_negative_out);
                    mismatches++;
                end
                if (o_overflow_out !== due.v) begin
                    $display("%0t: overflow expected %b, actual %b", $time, due.v,
                             o_overflow_out);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        start             <= 1'b0;
        i_cmd             <= CMD_ADD;
        i_op_size         <= SZ_BYTE;
        i_dst_is_register <= 1'b0;
        i_dst_value       <= '0;
        i_src_value       <= '0;
        i_carry_in        <= 1'b0;
        i_extend_in       <= 1'b0;
        i_zero_in         <= 1'b0;
        i_negative_in     <= 1'b0;
        i_overflow_in     <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_add_sub_edges();
        test_shift_counts();
        test_passthrough_cases();
        test_random_ops();
        start <= 1'b0;
        while (pending_alu_out.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
